// File: hw/rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define IAL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every rising edge, reset included.
`define IAL_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/ial_pkg.sv
`default_nettype none

package ial_pkg;

    localparam int DATA_W    = 32;
    localparam int IDX_W     = 7;
    localparam int CNT_W     = 8;
    localparam int FUNC_W    = 3;
    localparam int STAT_W    = 3;
    localparam int CAP_MAX   = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] CAP_RESET = 8'd128;

    // Cells examined per scan cycle.
    localparam int GRP_SZ    = 8;
    localparam int OFF_W     = 3;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int M_FIELD_W = STAT_W + IDX_W + DATA_W + CNT_W + 2;
    localparam int M_TDATA_W = 56;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT     = 3'd0,
        FN_REMOVE     = 3'd1,
        FN_APPEND     = 3'd2,
        FN_APPEND_UNQ = 3'd3,
        FN_SEARCH     = 3'd4,
        FN_UPDATE     = 3'd5,
        FN_READ       = 3'd6,
        FN_CLEAR      = 3'd7
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_RANGE = 3'd2,
        ST_DUP   = 3'd3,
        ST_NONE  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_APPEND,
        CELL_UPDATE,
        CELL_MATCH,
        CELL_SELECT
    } cell_op_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        cell_op_t              op;
        logic [IDX_W-1:0]      idx;
        logic [CNT_W-1:0]      cnt;
        logic [DATA_W-1:0]     value;
    } cell_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/ial_cell.sv
`default_nettype none

// One list slot. It takes its left or right neighbor's word to shift the
// list, loads the broadcast value, or flags a match or its selected position for the scanner.
module ial_cell #(
    parameter int POS_W = 7
) (
    input  wire logic                   clk,
    input  wire logic [POS_W-1:0]       pos,
    input  wire ial_pkg::cell_cmd_t     cmd,
    input  wire logic [ial_pkg::DATA_W-1:0] left,
    input  wire logic [ial_pkg::DATA_W-1:0] right,
    output      logic [ial_pkg::DATA_W-1:0] entry,
    output      logic                   hit
);
    import ial_pkg::*;

    localparam int CW = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    logic [DATA_W-1:0] entry_reg, entry_next;
    logic              hit_reg, hit_next;
    logic [CW-1:0]     pos_x, pos_p1, idx_x, cnt_x;

    always_comb
    begin
        pos_x      = CW'(pos);
        pos_p1     = pos_x + CW'(1);
        idx_x      = CW'(cmd.idx);
        cnt_x      = CW'(cmd.cnt);
        entry_next = entry_reg;
        hit_next   = hit_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (pos_x == idx_x)
                begin
                    entry_next = cmd.value;
                end
                else if (pos_x > idx_x && pos_x <= cnt_x)
                begin
                    entry_next = left;
                end
            end
            CELL_REMOVE:
            begin
                if (pos_x >= idx_x && pos_p1 < cnt_x)
                begin
                    entry_next = right;
                end
            end
            CELL_APPEND:
            begin
                if (pos_x == cnt_x)
                begin
                    entry_next = cmd.value;
                end
            end
            CELL_UPDATE:
            begin
                if (pos_x == idx_x)
                begin
                    entry_next = cmd.value;
                end
            end
            CELL_MATCH:
            begin
                hit_next = (entry_reg == cmd.value) && (pos_x < cnt_x);
            end
            CELL_SELECT:
            begin
                hit_next = (pos_x == idx_x);
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        hit_reg   <= hit_next;
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

`default_nettype wire

// File: hw/rtl/indexed_array_list.sv
`default_nettype none

// Channel   Dir  Beat contents (lowest bit first)
// s_*       in   tuser: func[2:0]; tdata: index[6:0], value[38:7], zero pad
// m_*       out  tdata: status[2:0], found_index[9:3], read_data[41:10],
//                item_count[49:42], is_full[50], is_empty[51], zero pad
// cfg_*     in   capacity[7:0], written on any edge with cfg_wr_en high
//
// One item is in flight at a time. After an item is accepted, insert, remove, append,
// update, clear and a read out of range go from evaluation straight to the result
// state; a read in range first selects its group in the scan state. Search and
// append-unique walk the 8-cell groups in the scan state up to the first match: the
// first group only on an empty list, else 1 to ceil(count/8) groups.
// Reset gives count 0 and capacity 128; the list words are not cleared.
// A new item is taken while a finished result still waits on m_tready; the
// next result then waits in its final state until the output register frees.
module indexed_array_list #(
    parameter int DEPTH = 128
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    input  wire logic [ial_pkg::S_TDATA_W-1:0]     s_tdata,  // index, value
    input  wire logic [ial_pkg::S_TUSER_W-1:0]     s_tuser,  // func
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    // status, found_index, read_data, item_count, is_full, is_empty
    output      logic [ial_pkg::M_TDATA_W-1:0]     m_tdata,
    input  wire logic                              cfg_wr_en,
    input  wire logic [ial_pkg::CNT_W-1:0]         cfg_wr_data
);
    import ial_pkg::*;

    localparam int POS_W = $clog2(DEPTH);
    localparam int NGRP  = (DEPTH + GRP_SZ - 1) / GRP_SZ;
    localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int NPAD  = (1 << GRP_W) * GRP_SZ;
    localparam int CMP_W = (GRP_W + OFF_W + 1 > CNT_W) ? GRP_W + OFF_W + 1 : CNT_W;
    localparam logic [CNT_W-1:0] CAP_SAT =
        (DEPTH > CAP_MAX) ? CNT_W'(CAP_MAX) : CNT_W'(DEPTH);
    localparam logic [GRP_W-1:0] LAST_GRP = GRP_W'(NGRP - 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    func_t             func_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [DATA_W-1:0] val_reg;
    logic [GRP_W-1:0]  grp_reg, grp_next;
    status_t           status_reg, status_next;
    logic [IDX_W-1:0]  found_reg, found_next;
    logic [DATA_W-1:0] rdata_reg, rdata_next;
    logic              m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic              accept;
    logic              load_out;
    logic [CNT_W-1:0]  eff_cap;
    logic              full;
    logic              scan_end;
    logic [CMP_W-1:0]  grp_limit;
    cell_cmd_t         cmd;

    logic [DATA_W-1:0] cell_entry [DEPTH];
    logic [DEPTH-1:0]  cell_hit;
    logic [DATA_W-1:0] pad_entry [NPAD];
    logic [NPAD-1:0]   pad_hit;

    logic              grp_any;
    logic [OFF_W-1:0]  grp_off;
    logic [DATA_W-1:0] grp_data;

    // Row of cells; each shifts with its neighbors under the broadcast command.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_w, right_w;
        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_entry[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = cell_entry[i+1];
        end
        ial_cell #(
            .POS_W (POS_W)
        ) u_cell (
            .clk   (clk),
            .pos   (POS_W'(i)),
            .cmd   (cmd),
            .left  (left_w),
            .right (right_w),
            .entry (cell_entry[i]),
            .hit   (cell_hit[i])
        );
    end

    // Pad the row to whole groups so every group select is in range.
    for (genvar j = 0; j < NPAD; j++)
    begin : g_pad
        if (j < DEPTH)
        begin : g_real
            assign pad_entry[j] = cell_entry[j];
            assign pad_hit[j]   = cell_hit[j];
        end
        else
        begin : g_zero
            assign pad_entry[j] = '0;
            assign pad_hit[j]   = 1'b0;
        end
    end

    // First flagged cell within the current group of eight.
    always_comb
    begin
        grp_any  = 1'b0;
        grp_off  = '0;
        grp_data = '0;
        for (int k = GRP_SZ - 1; k >= 0; k--)
        begin
            if (pad_hit[{grp_reg, OFF_W'(k)}])
            begin
                grp_any  = 1'b1;
                grp_off  = OFF_W'(k);
                grp_data = pad_entry[{grp_reg, OFF_W'(k)}];
            end
        end
    end

    assign eff_cap   = (cap_reg > CAP_SAT) ? CAP_SAT : cap_reg;
    assign full      = (count_reg >= eff_cap);
    assign grp_limit = CMP_W'({grp_reg, OFF_W'(0)}) + CMP_W'(GRP_SZ);
    assign scan_end  = (grp_reg == LAST_GRP) || (grp_limit >= CMP_W'(count_reg));
    assign accept    = s_tvalid && s_tready;

    // Sequencer: evaluate, optionally scan groups, then hand off the result.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        grp_next    = grp_reg;
        status_next = status_reg;
        found_next  = found_reg;
        rdata_next  = rdata_reg;
        cmd.op      = CELL_HOLD;
        cmd.idx     = idx_reg;
        cmd.cnt     = count_reg;
        cmd.value   = val_reg;
        s_tready    = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                status_next = ST_OK;
                found_next  = '0;
                rdata_next  = '0;
                state_next  = S_DONE;
                case (func_reg)
                    FN_INSERT:
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else if (CNT_W'(idx_reg) > count_reg)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            cmd.op     = CELL_INSERT;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    FN_REMOVE:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_NONE;
                        end
                        else if (CNT_W'(idx_reg) >= count_reg)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            cmd.op     = CELL_REMOVE;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    FN_APPEND:
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            cmd.op     = CELL_APPEND;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    FN_APPEND_UNQ, FN_SEARCH:
                    begin
                        cmd.op     = CELL_MATCH;
                        grp_next   = '0;
                        state_next = S_SCAN;
                    end
                    FN_UPDATE:
                    begin
                        if (CNT_W'(idx_reg) >= count_reg)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            cmd.op = CELL_UPDATE;
                        end
                    end
                    FN_READ:
                    begin
                        if (CNT_W'(idx_reg) >= count_reg)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            cmd.op     = CELL_SELECT;
                            grp_next   = GRP_W'(idx_reg >> OFF_W);
                            state_next = S_SCAN;
                        end
                    end
                    FN_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (grp_any)
                begin
                    state_next = S_DONE;
                    if (func_reg == FN_READ)
                    begin
                        rdata_next = grp_data;
                    end
                    else
                    begin
                        found_next = IDX_W'({grp_reg, grp_off});
                        if (func_reg == FN_APPEND_UNQ)
                        begin
                            status_next = ST_DUP;
                        end
                    end
                end
                else if (scan_end)
                begin
                    state_next = S_DONE;
                    if (func_reg == FN_SEARCH)
                    begin
                        status_next = ST_NONE;
                    end
                    else if (func_reg == FN_APPEND_UNQ)
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            cmd.op     = CELL_APPEND;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
                else
                begin
                    grp_next = grp_reg + GRP_W'(1);
                end
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cap_reg      <= CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Operation and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func_t'(s_tuser[FUNC_W-1:0]);
            idx_reg  <= s_tdata[IDX_W-1:0];
            val_reg  <= s_tdata[IDX_W +: DATA_W];
        end
        grp_reg    <= grp_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        rdata_reg  <= rdata_next;
        if (load_out)
        begin
            m_tdata_reg <= {{M_PAD_W{1'b0}},
                            (count_reg == '0),
                            full,
                            count_reg,
                            rdata_reg,
                            found_reg,
                            status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ial_checker.sv
`default_nettype none

`include "assert_macros.svh"

module ial_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [ial_pkg::M_TDATA_W-1:0] m_tdata
);
    import ial_pkg::*;

    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  found;
    logic [DATA_W-1:0] rdata;
    logic [CNT_W-1:0]  count;
    logic              empty;

    assign status = m_tdata[STAT_W-1:0];
    assign found  = m_tdata[STAT_W +: IDX_W];
    assign rdata  = m_tdata[STAT_W + IDX_W +: DATA_W];
    assign count  = m_tdata[STAT_W + IDX_W + DATA_W +: CNT_W];
    assign empty  = m_tdata[STAT_W + IDX_W + DATA_W + CNT_W + 1];

    `IAL_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")
    `IAL_ASSERT(a_status_code, clk, rst_n, m_tvalid |-> status <= ST_NONE, "status code out of range")
    `IAL_ASSERT(a_empty_flag, clk, rst_n, m_tvalid |-> (empty == (count == '0)), "empty flag disagrees with count")
    `IAL_ASSERT(a_refused_zero, clk, rst_n, m_tvalid && status != ST_OK |-> rdata == '0 && (status == ST_DUP || found == '0), "refused operation returned data")

endmodule

bind indexed_array_list ial_checker u_ial_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
